FILE: rtl/cwc_pkg.sv
package cwc_pkg;

    localparam int DEFAULT_MAX_VERTICES = 32;

    localparam int SIZE_W     = 6;
    localparam int LEN_W      = 8;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WALK_LENGTH = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = SIZE_W'(1);
    localparam logic [LEN_W-1:0]  WALK_LENGTH_RESET = LEN_W'(3);

    // status from the power engine to the top level
    typedef struct packed {
        logic busy;
        logic last_entry;
        logic done;
    } t_eng_stat;

endpackage

FILE: rtl/cwc_engine.sv
module cwc_engine
    import cwc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [VW-1:0]     i_n_last,
    input  logic [LEN_W-1:0]  i_walk_length,
    input  logic              i_load,
    input  logic              i_edge,
    output t_eng_stat         o_stat,
    output logic [DATA_W-1:0] o_count
);

    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ACC,
        S_ACC_END,
        S_WB,
        S_TRACE,
        S_TRACE_END
    } t_state;

    // running power, row-major, row in the upper address bits
    logic [DATA_W-1:0]       pmem [DEPTH];
    // one adjacency mask per row
    logic [MAX_VERTICES-1:0] amem [MAX_VERTICES];

    t_state                  r_state;
    logic [VW-1:0]           r_row;
    logic [VW-1:0]           r_col;
    logic [VW-1:0]           r_i;
    logic [VW-1:0]           r_k;
    logic [LEN_W-1:0]        r_step;
    logic [LEN_W-1:0]        r_len;
    logic                    r_v;
    logic                    r_first;
    logic                    r_trace;

    logic [MAX_VERTICES-1:0] r_row_bits;
    logic [MAX_VERTICES-1:0] n_row_bits;
    logic [DATA_W-1:0]       r_pdata;
    logic [MAX_VERTICES-1:0] r_adj;
    logic [DATA_W-1:0]       r_acc [MAX_VERTICES];
    logic [DATA_W-1:0]       r_sum;

    logic                    pm_we;
    logic [AW-1:0]           pm_waddr;
    logic [DATA_W-1:0]       pm_wdata;
    logic                    pm_re;
    logic [AW-1:0]           pm_raddr;
    logic                    am_we;
    logic                    am_re;
    logic                    row_end;
    logic                    mat_end;
    logic [LEN_W-1:0]        len_eff;

    assign row_end = (r_col == i_n_last);
    assign mat_end = row_end && (r_row == i_n_last);
    assign len_eff = (i_walk_length == '0) ? LEN_W'(1) : i_walk_length;

    always_comb begin
        n_row_bits        = r_row_bits;
        n_row_bits[r_col] = i_edge;
    end

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = {r_row, r_col};
        pm_wdata = DATA_W'(i_edge);
        pm_re    = 1'b0;
        pm_raddr = {r_i, r_k};
        am_we    = 1'b0;
        am_re    = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                pm_we = i_load;
                am_we = i_load && row_end;
            end
            S_ACC: begin
                pm_re = 1'b1;
                am_re = 1'b1;
            end
            S_WB: begin
                pm_we    = 1'b1;
                pm_waddr = {r_i, r_k};
                pm_wdata = r_acc[r_k];
            end
            S_TRACE: begin
                pm_re    = 1'b1;
                pm_raddr = {r_i, r_i};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            pmem[pm_waddr] <= pm_wdata;
        end
        if (pm_re) begin
            r_pdata <= pmem[pm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (am_we) begin
            amem[r_row] <= n_row_bits;
        end
        if (am_re) begin
            r_adj <= amem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row_bits <= n_row_bits;
        end
    end

    // one lane per column: new row of P*A built over k
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (r_v && !r_trace) begin
                if (r_first) begin
                    r_acc[j] <= r_adj[j] ? r_pdata : '0;
                end else if (r_adj[j]) begin
                    r_acc[j] <= r_acc[j] + r_pdata;
                end
            end
        end
        if (r_v && r_trace) begin
            r_sum <= r_first ? r_pdata : r_sum + r_pdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_row   <= '0;
            r_col   <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_step  <= '0;
            r_len   <= '0;
            r_v     <= 1'b0;
            r_first <= 1'b0;
            r_trace <= 1'b0;
        end else begin
            r_v     <= pm_re;
            r_trace <= (r_state == S_TRACE);
            r_first <= (r_state == S_TRACE) ? (r_i == '0) : (r_k == '0);
            unique case (r_state)
                S_LOAD: begin
                    if (i_restart) begin
                        r_row <= '0;
                        r_col <= '0;
                    end else if (i_load) begin
                        if (row_end) begin
                            r_col <= '0;
                            r_row <= mat_end ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (mat_end) begin
                            r_i    <= '0;
                            r_k    <= '0;
                            r_len  <= len_eff;
                            r_step <= LEN_W'(1);
                            r_state <= (len_eff == LEN_W'(1)) ? S_TRACE : S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (r_k == i_n_last) begin
                        r_k     <= '0;
                        r_state <= S_ACC_END;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_ACC_END: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_k == i_n_last) begin
                        r_k <= '0;
                        if (r_i == i_n_last) begin
                            r_i <= '0;
                            if (r_step + 1'b1 == r_len) begin
                                r_state <= S_TRACE;
                            end else begin
                                r_step  <= r_step + 1'b1;
                                r_state <= S_ACC;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_ACC;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_TRACE: begin
                    if (r_i == i_n_last) begin
                        r_i     <= '0;
                        r_state <= S_TRACE_END;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_TRACE_END: begin
                    r_state <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // last diagonal word is added combinationally in S_TRACE_END
    assign o_count           = r_first ? r_pdata : r_sum + r_pdata;
    assign o_stat.busy       = (r_state != S_LOAD);
    assign o_stat.last_entry = mat_end;
    assign o_stat.done       = (r_state == S_TRACE_END);

endmodule

FILE: rtl/closed_walk_counter_core.sv
// closed walk counter: trace of the 0/1 adjacency matrix raised to the walk length
//
// input channel: one transaction per matrix entry (i_edge_weight), row-major,
// n*n entries per matrix; an entry is an edge when it is nonzero. entries that
// do not complete the matrix are taken one per cycle when idle and give no result.
// output channel: one transaction (o_walk_count) per completed matrix.
// after the entry that completes the matrix, the engine computes A^L (L=0
// counts as 1) in its power memory, one row at a time: memory reads feed
// 32-bit column lanes, a drain state follows, then the row of the new power
// is written back. the trace then reads the n diagonal words and the count
// is registered in the output register.
// o_stall is high for the whole computation. when the receiver stalls, the
// count holds in the output register; further entries are still taken, only
// the entry that would complete the next matrix waits until the count leaves.
// reset (synchronous, active low) sets n=1, L=3 and restarts the load; the
// memories are not cleared. writing matrix_size restarts the load.
// config writes are only allowed while the block is idle.
module closed_walk_counter_core
    import cwc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // entry channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_W-1:0]     i_edge_weight,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_W-1:0]     o_walk_count
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic [SIZE_W-1:0] r_matrix_size;
    logic [LEN_W-1:0]  r_walk_length;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_walk_count;

    logic [SIZE_W:0]   size_ext;
    logic [SIZE_W:0]   n_last_ext;
    logic [VW-1:0]     n_last;
    logic              cfg_size_wr;
    logic              in_xact;
    logic              out_xact;
    t_eng_stat         eng_stat;
    logic [DATA_W-1:0] eng_count;

    assign cfg_size_wr = i_cfg_we && (i_cfg_index == REG_MATRIX_SIZE);

    // clamp n to 1..MAX_VERTICES, carried as n-1
    assign size_ext = {1'b0, r_matrix_size};
    always_comb begin
        if (r_matrix_size == '0) begin
            n_last_ext = '0;
        end else if (size_ext > (SIZE_W+1)'(MAX_VERTICES)) begin
            n_last_ext = (SIZE_W+1)'(MAX_VERTICES - 1);
        end else begin
            n_last_ext = size_ext - 1'b1;
        end
    end
    assign n_last = n_last_ext[VW-1:0];

    // the completing entry waits for a free output register
    assign o_stall  = eng_stat.busy || (r_out_valid && eng_stat.last_entry);
    assign in_xact  = i_valid && !o_stall;
    assign out_xact = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MATRIX_SIZE_RESET;
            r_walk_length <= WALK_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MATRIX_SIZE: r_matrix_size <= i_cfg_data[SIZE_W-1:0];
                REG_WALK_LENGTH: r_walk_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cwc_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_size_wr),
        .i_n_last      (n_last),
        .i_walk_length (r_walk_length),
        .i_load        (in_xact),
        .i_edge        (i_edge_weight != '0),
        .o_stat        (eng_stat),
        .o_count       (eng_count)
    );

    // output register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (out_xact) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.done) begin
            r_walk_count <= eng_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_walk_count = r_walk_count;

endmodule
